/* rtl/usm_pkg.sv */
// Shared types and constants for the unsharp-mask 3x3 box filter.
package usm_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int CHANNEL_BITS = 8;
    localparam int CHANNELS     = 3;
    localparam int PIX_BITS     = CHANNELS * CHANNEL_BITS;
    localparam int WIN_CELLS    = 9;

    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int EW_BITS      = $clog2(MAX_WIDTH + 1);
    localparam int IN_ROW_BITS  = 17;
    localparam int OUT_ROW_BITS = 16;
    localparam int FW_BITS      = 12;
    localparam int FH_BITS      = 16;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    localparam int FW_RESET = 640;
    localparam int FH_RESET = 480;

    // bits for the largest 3x3 sum of one channel
    localparam int SUM_BITS    = $clog2(WIN_CELLS * ((1 << CHANNEL_BITS) - 1) + 1);
    // floor(s/d) = (s * ceil(2^k/d)) >> k, exact over the sum range
    localparam int RECIP_SHIFT = 14;
    localparam int RECIP_BITS  = 12;
    localparam logic [RECIP_BITS-1:0] RECIP6 = RECIP_BITS'(((1 << RECIP_SHIFT) + 5) / 6);
    localparam logic [RECIP_BITS-1:0] RECIP9 = RECIP_BITS'(((1 << RECIP_SHIFT) + 8) / 9);
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [PIX_BITS-1:0] pix_t;
    typedef logic [WIN_CELLS-1:0][CHANNEL_BITS-1:0] win_chan_t;

    typedef enum logic [1:0] {
        DIV4,
        DIV6,
        DIV9
    } div_sel_t;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } border_t;

    typedef struct packed {
        logic    due;
        logic    last;
        border_t border;
    } item_ctl_t;

endpackage

/* rtl/usm_line_buf.sv */
// Two-row line buffer: one RAM word per column holding the older and newer row.
module usm_line_buf
(
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [usm_pkg::COL_BITS-1:0]  rd_addr,
    output logic [2*usm_pkg::PIX_BITS-1:0] rd_data,
    input  logic                          wr_en,
    input  logic [usm_pkg::COL_BITS-1:0]  wr_addr,
    input  logic [2*usm_pkg::PIX_BITS-1:0] wr_data
);

    logic [2*usm_pkg::PIX_BITS-1:0] mem [usm_pkg::MAX_WIDTH];
    logic [2*usm_pkg::PIX_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // same-cycle write to the read column is forwarded
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/usm_lane.sv */
// One colour lane: masked 3x3 sum, constant divide and sharpening.
module usm_lane
(
    input  logic                   clk,
    input  logic                   load,
    input  usm_pkg::win_chan_t     win,
    input  usm_pkg::border_t       border,
    output usm_pkg::chan_t         sharp
);

    logic [usm_pkg::SUM_BITS-1:0]   sum;
    logic [usm_pkg::SUM_BITS-1:0]   sum_reg;
    usm_pkg::chan_t                 orig_reg;
    usm_pkg::div_sel_t              div_sel;
    usm_pkg::div_sel_t              div_reg;
    logic [usm_pkg::PROD_BITS-1:0]  prod;
    usm_pkg::chan_t                 smooth;
    logic                           v_edge;
    logic                           h_edge;

    always_comb
    begin
        sum = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (!((r == 0 && border.top) || (r == 2 && border.bottom) ||
                      (c == 0 && border.left) || (c == 2 && border.right)))
                begin
                    sum = sum + usm_pkg::SUM_BITS'(win[r*3 + c]);
                end
            end
        end
    end

    assign v_edge = border.top || border.bottom;
    assign h_edge = border.left || border.right;

    always_comb
    begin
        if (v_edge && h_edge)
        begin
            div_sel = usm_pkg::DIV4;
        end
        else if (v_edge || h_edge)
        begin
            div_sel = usm_pkg::DIV6;
        end
        else
        begin
            div_sel = usm_pkg::DIV9;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg  <= sum;
            orig_reg <= win[4];
            div_reg  <= div_sel;
        end
    end

    always_comb
    begin
        prod   = '0;
        smooth = '0;
        case (div_reg)
            usm_pkg::DIV4:
            begin
                smooth = usm_pkg::CHANNEL_BITS'(sum_reg >> 2);
            end
            usm_pkg::DIV6:
            begin
                prod   = usm_pkg::PROD_BITS'(sum_reg) * usm_pkg::PROD_BITS'(usm_pkg::RECIP6);
                smooth = usm_pkg::CHANNEL_BITS'(prod >> usm_pkg::RECIP_SHIFT);
            end
            usm_pkg::DIV9:
            begin
                prod   = usm_pkg::PROD_BITS'(sum_reg) * usm_pkg::PROD_BITS'(usm_pkg::RECIP9);
                smooth = usm_pkg::CHANNEL_BITS'(prod >> usm_pkg::RECIP_SHIFT);
            end
            default:
            begin
                smooth = '0;
            end
        endcase
    end

    // 2*orig - smooth, wrapping
    assign sharp = {orig_reg[usm_pkg::CHANNEL_BITS-2:0], 1'b0} - smooth;

endmodule

/* rtl/unsharp_mask_box3x3_rgb.sv */
// Unsharp mask with 3x3 box blur over an RGB raster stream (top level).
//
// Takes one beat per clock while pix_stall is low: pixels of a frame in raster order, then
// frame_width+1 flush beats. The result for raster pixel n leaves on the result channel
// once item n+frame_width+1 is in, after that item passes the stage 1, window, lane and
// output registers. A pixel beat may follow in the next cycle without limit; the single
// 2048 x 48 line buffer RAM (one read, one write per cycle) and a four-register pipeline
// set that rate, and a result held by a stalled output costs no input cycle until the
// pipeline fills. The line buffer needs no clearing after reset. Each channel runs in its
// own lane; the output register merges the three lanes and carries frame_end on the
// frame's last pixel. frame_width is clamped to 2..2048 and frame_height to at least 2;
// write them only while the block is idle.
module unsharp_mask_box3x3_rgb
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 pix_valid,
    output logic                                 pix_stall,
    input  logic                                 func,
    input  logic [usm_pkg::CHANNEL_BITS-1:0]     red_in,
    input  logic [usm_pkg::CHANNEL_BITS-1:0]     green_in,
    input  logic [usm_pkg::CHANNEL_BITS-1:0]     blue_in,

    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic [usm_pkg::CHANNEL_BITS-1:0]     red_out,
    output logic [usm_pkg::CHANNEL_BITS-1:0]     green_out,
    output logic [usm_pkg::CHANNEL_BITS-1:0]     blue_out,
    output logic                                 frame_end,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [usm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [usm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    // configuration
    logic [usm_pkg::FW_BITS-1:0]      fw_reg;
    logic [usm_pkg::FH_BITS-1:0]      fh_reg;
    logic [usm_pkg::EW_BITS-1:0]      eff_w;
    logic [usm_pkg::FH_BITS-1:0]      eff_h;

    // stream position
    logic [usm_pkg::COL_BITS-1:0]     in_col_reg, in_col_next;
    logic [usm_pkg::IN_ROW_BITS-1:0]  in_row_reg, in_row_next;
    logic [usm_pkg::COL_BITS-1:0]     out_col_reg, out_col_next;
    logic [usm_pkg::OUT_ROW_BITS-1:0] out_row_reg, out_row_next;

    logic [usm_pkg::EW_BITS-1:0]      in_col_inc;
    logic [usm_pkg::EW_BITS-1:0]      out_col_inc;
    logic                             in_wrap;
    logic                             out_wrap;
    logic                             pixel_phase;
    usm_pkg::pix_t                    cur;
    usm_pkg::item_ctl_t               ctl;

    // pipeline control
    logic                             accept;
    logic                             s1_free, s1_go;
    logic                             s2_free, s2_adv;
    logic                             s3_free, s3_adv;
    logic                             out_free;

    logic                             s1_valid_reg;
    logic [usm_pkg::COL_BITS-1:0]     s1_addr_reg;
    usm_pkg::pix_t                    s1_cur_reg;
    usm_pkg::item_ctl_t               s1_ctl_reg;
    logic [2*usm_pkg::PIX_BITS-1:0]   row_data;
    usm_pkg::pix_t                    col_up;
    usm_pkg::pix_t                    col_mid;

    logic                             s2_valid_reg;
    usm_pkg::item_ctl_t               s2_ctl_reg;
    usm_pkg::pix_t                    win_reg [usm_pkg::WIN_CELLS];

    logic                             s3_valid_reg;
    logic                             s3_last_reg;

    logic                             res_valid_reg;
    usm_pkg::chan_t                   red_reg, green_reg, blue_reg;
    logic                             frame_end_reg;

    usm_pkg::win_chan_t               win_ch [usm_pkg::CHANNELS];
    usm_pkg::chan_t                   sharp [usm_pkg::CHANNELS];

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= usm_pkg::FW_BITS'(usm_pkg::FW_RESET);
            fh_reg <= usm_pkg::FH_BITS'(usm_pkg::FH_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                usm_pkg::REG_FRAME_WIDTH:  fw_reg <= cfg_data[usm_pkg::FW_BITS-1:0];
                usm_pkg::REG_FRAME_HEIGHT: fh_reg <= cfg_data[usm_pkg::FH_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (fw_reg < usm_pkg::FW_BITS'(2))
        begin
            eff_w = usm_pkg::EW_BITS'(2);
        end
        else if (32'(fw_reg) > usm_pkg::MAX_WIDTH)
        begin
            eff_w = usm_pkg::EW_BITS'(usm_pkg::MAX_WIDTH);
        end
        else
        begin
            eff_w = usm_pkg::EW_BITS'(fw_reg);
        end
    end

    assign eff_h = (fh_reg < usm_pkg::FH_BITS'(2)) ? usm_pkg::FH_BITS'(2) : fh_reg;

    // ---------------- handshake chain ----------------
    assign out_free  = !res_valid_reg || !res_stall;
    assign s3_adv    = s3_valid_reg && out_free;
    assign s3_free   = !s3_valid_reg || out_free;
    assign s2_adv    = s2_valid_reg && s3_free;
    assign s2_free   = !s2_valid_reg || s3_free;
    assign s1_go     = s1_valid_reg && s2_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign pix_stall = !s1_free;
    assign accept    = pix_valid && s1_free;

    // ---------------- position tracking ----------------
    assign pixel_phase = usm_pkg::IN_ROW_BITS'(eff_h) > in_row_reg;
    assign cur = (pixel_phase && (func == usm_pkg::FUNC_PIXEL)) ?
                 {red_in, green_in, blue_in} : '0;

    assign in_col_inc  = usm_pkg::EW_BITS'(in_col_reg) + usm_pkg::EW_BITS'(1);
    assign out_col_inc = usm_pkg::EW_BITS'(out_col_reg) + usm_pkg::EW_BITS'(1);
    assign in_wrap     = in_col_inc >= eff_w;
    assign out_wrap    = out_col_inc >= eff_w;

    always_comb
    begin
        ctl.due = (in_row_reg >= usm_pkg::IN_ROW_BITS'(2)) ||
                  ((in_row_reg == usm_pkg::IN_ROW_BITS'(1)) && (in_col_reg != '0));
        ctl.border.top    = out_row_reg == '0;
        ctl.border.bottom = out_row_reg >= (eff_h - usm_pkg::FH_BITS'(1));
        ctl.border.left   = out_col_reg == '0;
        ctl.border.right  = usm_pkg::EW_BITS'(out_col_reg) >= (eff_w - usm_pkg::EW_BITS'(1));
        ctl.last          = ctl.border.bottom && ctl.border.right;
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept)
        begin
            if (!ctl.due)
            begin
                if (in_wrap)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + usm_pkg::IN_ROW_BITS'(1);
                end
                else
                begin
                    in_col_next = in_col_inc[usm_pkg::COL_BITS-1:0];
                end
            end
            else if (ctl.last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else
            begin
                if (out_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + usm_pkg::OUT_ROW_BITS'(1);
                end
                else
                begin
                    out_col_next = out_col_inc[usm_pkg::COL_BITS-1:0];
                end
                if (in_wrap)
                begin
                    in_col_next = '0;
                    if (in_row_reg != '1)
                    begin
                        in_row_next = in_row_reg + usm_pkg::IN_ROW_BITS'(1);
                    end
                end
                else
                begin
                    in_col_next = in_col_inc[usm_pkg::COL_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ---------------- stage 1: line buffer read ----------------
    usm_line_buf u_line_buf
    (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (in_col_reg),
        .rd_data (row_data),
        .wr_en   (s1_go),
        .wr_addr (s1_addr_reg),
        .wr_data ({col_mid, s1_cur_reg})
    );

    assign col_up  = row_data[2*usm_pkg::PIX_BITS-1:usm_pkg::PIX_BITS];
    assign col_mid = row_data[usm_pkg::PIX_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= in_col_reg;
            s1_cur_reg  <= cur;
            s1_ctl_reg  <= ctl;
        end
    end

    // ---------------- stage 2: 3x3 window ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < usm_pkg::WIN_CELLS; i++)
            begin
                win_reg[i] <= '0;
            end
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_go)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]     <= win_reg[r*3 + 1];
                    win_reg[r*3 + 1] <= win_reg[r*3 + 2];
                end
                win_reg[2] <= col_up;
                win_reg[5] <= col_mid;
                win_reg[8] <= s1_cur_reg;
                s2_valid_reg <= s1_ctl_reg.due;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    // ---------------- stage 3: colour lanes ----------------
    always_comb
    begin
        for (int k = 0; k < usm_pkg::CHANNELS; k++)
        begin
            for (int i = 0; i < usm_pkg::WIN_CELLS; i++)
            begin
                win_ch[k][i] = win_reg[i][usm_pkg::CHANNEL_BITS*(usm_pkg::CHANNELS-1-k) +:
                                          usm_pkg::CHANNEL_BITS];
            end
        end
    end

    for (genvar k = 0; k < usm_pkg::CHANNELS; k++)
    begin : g_lane
        usm_lane u_lane
        (
            .clk    (clk),
            .load   (s2_adv),
            .win    (win_ch[k]),
            .border (s2_ctl_reg.border),
            .sharp  (sharp[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            s3_valid_reg <= 1'b1;
        end
        else if (s3_adv)
        begin
            s3_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s3_last_reg <= s2_ctl_reg.last;
        end
    end

    // ---------------- merge into the output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s3_adv)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            red_reg       <= sharp[0];
            green_reg     <= sharp[1];
            blue_reg      <= sharp[2];
            frame_end_reg <= s3_last_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign frame_end = frame_end_reg;

    // ---------------- assertions ----------------
    a_last_is_corner : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_ctl_reg.last |->
            s1_ctl_reg.due && s1_ctl_reg.border.bottom && s1_ctl_reg.border.right)
        else $error("last flag without bottom-right position");

    a_s1_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_valid_reg |-> s1_go)
        else $error("stage 1 overwritten while holding an item");

    a_rows_not_both : assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> !(s2_ctl_reg.border.top && s2_ctl_reg.border.bottom))
        else $error("window cut at both top and bottom");

    a_cols_not_both : assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> !(s2_ctl_reg.border.left && s2_ctl_reg.border.right))
        else $error("window cut at both left and right");

    a_result_from_s3 : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(s3_valid_reg))
        else $error("result without an item in the lane stage");

endmodule
